### design/tcw_pkg.sv
// Package: geometry, character codes and command codes of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W  = 11;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CELL_W-1:0] CELL_RESET   = 16'h0720;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } reg_idx_t;

endpackage

### design/text_console_writer_core.sv
// Top level: text console writer with screen store, cursor tracking and sequencer.
`timescale 1ns / 1ps
// Text-mode console over an 80x25 screen store of 16-bit cells (attribute in
// the high byte, character in the low byte), held in one RAM with a single
// write and a single registered read port. After reset a clearing pass
// writes all 2000 cells with light grey spaces; no beat is accepted
// meanwhile, colour writes are. A put that does not scroll, a backspace, an
// unused command and a read beyond the screen go from accept straight to the
// output register; a read of a cell first waits for the registered RAM data.
// A scroll copies 1920 cells, each read and then written over the single
// RAM port, then blanks the bottom row. A clear writes all 2000 cells. The
// cursor's linear position has its own register, updated incrementally.
module text_console_writer_core
  import tcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [COLOR_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic [CHAR_W-1:0]   in_char_code,
  input  logic [ADDR_W-1:0]   in_cell_address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COL_W-1:0]    out_cursor_column,
  output logic [ROW_W-1:0]    out_cursor_row,
  output logic [ADDR_W-1:0]   out_cursor_position,
  output logic                out_scrolled,
  output logic [CELL_W-1:0]   out_read_cell
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_OUT
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [COLOR_W-1:0]  fg_r, fg_nxt;
  logic [COLOR_W-1:0]  bg_r, bg_nxt;
  logic                scr_r, scr_nxt;
  logic [CELL_W-1:0]   cell_r, cell_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [COL_W-1:0]    ocol_r, ocol_nxt;
  logic [ROW_W-1:0]    orow_r, orow_nxt;
  logic [ADDR_W-1:0]   opos_r, opos_nxt;
  logic                oscr_r, oscr_nxt;
  logic [CELL_W-1:0]   ocell_r, ocell_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  logic                accept;
  logic                last_row;
  logic [CELL_W-1:0]   blank;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_row = (row_r == ROW_W'(ROWS - 1));
  assign blank    = {bg_r, fg_r, CH_SPACE};

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    pos_nxt    = pos_r;
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    scr_nxt    = scr_r;
    cell_nxt   = cell_r;
    ovalid_nxt = ovalid_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    opos_nxt   = opos_r;
    oscr_nxt   = oscr_r;
    ocell_nxt  = ocell_r;
    ram_we     = 1'b0;
    ram_waddr  = cnt_r;
    ram_wdata  = blank;
    ram_raddr  = in_cell_address;

    if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_FG:  fg_nxt = cfg_wr_data;
        REG_BG:  bg_nxt = cfg_wr_data;
        default: ;
      endcase
    end

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = CELL_RESET;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          scr_nxt   = 1'b0;
          cell_nxt  = '0;
          state_nxt = ST_OUT;
          case (cmd_t'(in_command))
            CMD_PUT: begin
              if (in_char_code == CH_BACKSPACE) begin
                if (col_r != '0) begin
                  col_nxt = col_r - 1'b1;
                  pos_nxt = pos_r - 1'b1;
                end
              end else begin
                if (in_char_code != CH_NEWLINE) begin
                  ram_we    = 1'b1;
                  ram_waddr = pos_r;
                  ram_wdata = {bg_r, fg_r, in_char_code};
                end
                if (in_char_code != CH_NEWLINE && col_r != COL_W'(COLUMNS - 1)) begin
                  col_nxt = col_r + 1'b1;
                  pos_nxt = pos_r + 1'b1;
                end else if (last_row) begin
                  col_nxt   = '0;
                  pos_nxt   = LAST_ROW_BASE;
                  scr_nxt   = 1'b1;
                  cnt_nxt   = COLS_A;
                  state_nxt = ST_SCR_RD;
                end else begin
                  col_nxt = '0;
                  row_nxt = row_r + 1'b1;
                  pos_nxt = pos_r - ADDR_W'(col_r) + COLS_A;
                end
              end
            end
            CMD_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              pos_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            CMD_READ: begin
              if (in_cell_address <= LAST_CELL) begin
                state_nxt = ST_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD_WAIT: begin
        cell_nxt  = ram_rdata;
        state_nxt = ST_OUT;
      end
      ST_SCR_RD: begin
        ram_raddr = cnt_r;
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r - COLS_A;
        ram_wdata = ram_rdata;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = LAST_ROW_BASE;
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_SCR_RD;
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = blank;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          ocol_nxt   = col_r;
          orow_nxt   = row_r;
          opos_nxt   = pos_r;
          oscr_nxt   = scr_r;
          ocell_nxt  = cell_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      cnt_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      pos_r    <= '0;
      fg_r     <= FG_RESET;
      bg_r     <= BG_RESET;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pos_r    <= pos_nxt;
      fg_r     <= fg_nxt;
      bg_r     <= bg_nxt;
      ovalid_r <= ovalid_nxt;
    end
    scr_r   <= scr_nxt;
    cell_r  <= cell_nxt;
    ocol_r  <= ocol_nxt;
    orow_r  <= orow_nxt;
    opos_r  <= opos_nxt;
    oscr_r  <= oscr_nxt;
    ocell_r <= ocell_nxt;
  end

  assign out_valid           = ovalid_r;
  assign out_cursor_column   = ocol_r;
  assign out_cursor_row      = orow_r;
  assign out_cursor_position = opos_r;
  assign out_scrolled        = oscr_r;
  assign out_read_cell       = ocell_r;

endmodule

### design/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
